### design/disk_pair_collision_response_core_macros.svh
// Assertion macros shared by the disk pair collision response design.
// No dependencies.
`ifndef DISK_PAIR_COLLISION_RESPONSE_CORE_MACROS_SVH
`define DISK_PAIR_COLLISION_RESPONSE_CORE_MACROS_SVH
`define DPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### design/dpc_pkg.sv
// Package for the disk pair collision response core.
// Holds the number format constants, item types and the per-stage working record.
package dpc_pkg;
  localparam int FRAC_BITS = 16;
  localparam int UNIT_BITS = 29;
  localparam int SCALE_BITS = 16;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_BITS = 31;
  localparam int PIPE_DEPTH = 72;

  localparam logic CFG_VELOCITY_SCALE = 1'b0;
  localparam logic CFG_PARTICLE_RADIUS = 1'b1;

  typedef struct packed {
    logic signed [31:0] second_vy;
    logic signed [31:0] second_vx;
    logic signed [31:0] second_y;
    logic signed [31:0] second_x;
    logic signed [31:0] first_vy;
    logic signed [31:0] first_vx;
    logic signed [31:0] first_y;
    logic signed [31:0] first_x;
  } pair_t;

  typedef struct packed {
    logic coincident;
    logic collided;
    pair_t pair;
  } result_t;

  // Per-stage working record.
  typedef struct packed {
    pair_t pair;
    logic act;
    logic coin;
    logic dxn;
    logic dyn;
    logic dyp;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [29:0] a;
    logic [29:0] b;
    logic [63:0] rem;
    logic [31:0] root;
    logic [63:0] rem2;
    logic [31:0] root2;
    logic [60:0] qc;
    logic [60:0] qs;
    logic [31:0] dcap;
    logic [60:0] rc;
    logic [60:0] rs;
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [67:0] t0;
    logic signed [67:0] t1;
    logic signed [67:0] t2;
    logic signed [67:0] t3;
    logic ov;
  } work_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

### design/dpc_stage.sv
// One pipeline stage register for the working record, with a stall-safe valid bit.
// Depends on dpc_pkg for the record type.
module dpc_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  dpc_pkg::work_t in_data,
  output logic           out_valid,
  output dpc_pkg::work_t out_data
);
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= in_data;
    end
  end
endmodule

### design/disk_pair_collision_response_core.sv
// Disk pair collision response core: top level.
// One item is accepted every cycle when the output is taken; the depth is set by the
// two side-by-side 32-step square roots and the 31-step dividers.
// A stall freezes the whole pipeline; nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the register reset values.
`include "disk_pair_collision_response_core_macros.svh"
module disk_pair_collision_response_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_x, first_y, first_vx, first_vy, second_x, second_y, second_vx, second_vy
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_first_x .. new_second_vy in input order, then collided, coincident
  output logic [263:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  localparam int D = dpc_pkg::PIPE_DEPTH;

  logic [16:0] velocity_scale;
  logic [24:0] particle_radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_scale <= 17'd65536;
      particle_radius <= 25'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        dpc_pkg::CFG_VELOCITY_SCALE: velocity_scale <= cfg_data[16:0];
        dpc_pkg::CFG_PARTICLE_RADIUS: particle_radius <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [D:0] vld;
  dpc_pkg::work_t st [D+1];

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign vld[0] = s_axis_tvalid;

  function automatic logic [31:0] umag(input logic signed [32:0] v);
    logic [32:0] t;
    t = v[32] ? -v : v;
    return t[31:0];
  endfunction

  function automatic logic signed [67:0] rshr(input logic signed [67:0] x);
    logic signed [67:0] t;
    t = x + 68'sd268435456;
    return t >>> dpc_pkg::UNIT_BITS;
  endfunction

  function automatic logic signed [67:0] smul(input logic signed [34:0] x,
                                              input logic signed [31:0] y);
    return 68'(x) * 68'(y);
  endfunction

  assign st[0] = {s_axis_tdata, {($bits(dpc_pkg::work_t) - 256){1'b0}}};

  genvar g;
  generate
    for (g = 0; g < D; g++) begin : g_pipe
      dpc_pkg::work_t nx;
      always_comb begin
        dpc_pkg::work_t w;
        logic signed [32:0] dx, dy, rx, ry;
        logic [31:0] m;
        logic [63:0] tr;
        logic [61:0] tq;
        logic [25:0] twor;
        logic [51:0] tw2;
        logic signed [67:0] p0, p1;
        logic signed [32:0] push;
        w = st[g];
        dx = 33'(w.pair.first_x) - 33'(w.pair.second_x);
        dy = 33'(w.pair.first_y) - 33'(w.pair.second_y);
        twor = {particle_radius, 1'b0};
        tr = '0; tq = '0; m = '0; tw2 = '0; p0 = '0; p1 = '0; push = '0;
        rx = '0; ry = '0;
        if (g == 0) begin
          rx = (w.pair.first_x < w.pair.second_x) ?
            33'(w.pair.first_vx) - 33'(w.pair.second_vx) :
            33'(w.pair.second_vx) - 33'(w.pair.first_vx);
          ry = (w.pair.first_y < w.pair.second_y) ?
            33'(w.pair.first_vy) - 33'(w.pair.second_vy) :
            33'(w.pair.second_vy) - 33'(w.pair.first_vy);
          w.coin = (dx == 0) && (dy == 0);
          if (rx > 0 && ry > 0) w.act = 1'b1;
          else if (rx < 0 && ry < 0) w.act = 1'b0;
          else if (rx > 0 && ry < 0) w.act = rx > ry;
          else w.act = ry > rx;
          w.act = w.act && !w.coin;
          w.dxn = dx[32];
          w.dyn = dy[32];
          w.dyp = !dy[32] && (dy != 0);
          w.ma = umag(dx);
          w.mb = umag(dy);
        end else if (g == 1) begin
          m = (w.ma > w.mb) ? w.ma : w.mb;
          w.a = '0; w.b = '0;
          for (int k = 0; k < 32; k++) begin
            if (m[k]) begin
              if (k >= 28) begin
                w.a = 30'(w.ma >> (k - 28));
                w.b = 30'(w.mb >> (k - 28));
              end else begin
                w.a = 30'(w.ma << (28 - k));
                w.b = 30'(w.mb << (28 - k));
              end
            end
          end
          w.rem = 64'(w.a) * 64'(w.a);
          w.rem2 = 64'(w.ma) * 64'(w.ma);
        end else if (g == 2) begin
          w.rem = w.rem + 64'(w.b) * 64'(w.b);
          w.rem2 = w.rem2 + 64'(w.mb) * 64'(w.mb);
          tw2 = 52'(twor) * 52'(twor);
          w.ov = (w.ma < 32'(twor)) && (w.mb < 32'(twor)) && (w.rem2 < 64'(tw2));
          w.root = '0; w.root2 = '0;
        end else if (g < 3 + dpc_pkg::SQRT_STEPS) begin
          // One restoring square root bit for both radicands.
          tr = ({32'd0, w.root} << (35 - g)) | (64'd1 << (2 * (34 - g)));
          if (w.rem >= tr) begin
            w.rem = w.rem - tr;
            w.root = w.root | (32'd1 << (34 - g));
          end
          tr = ({32'd0, w.root2} << (35 - g)) | (64'd1 << (2 * (34 - g)));
          if (w.rem2 >= tr) begin
            w.rem2 = w.rem2 - tr;
            w.root2 = w.root2 | (32'd1 << (34 - g));
          end
          if (g == 2 + dpc_pkg::SQRT_STEPS) begin
            w.dcap = w.root;
            w.rc = 61'({w.a, 29'd0});
            w.rs = 61'({w.b, 29'd0});
            w.qc = '0; w.qs = '0;
          end
        end else if (g < 3 + dpc_pkg::SQRT_STEPS + dpc_pkg::DIV_BITS) begin
          // One quotient bit of a<<29/d and b<<29/d, high bit first.
          tq = 62'(w.dcap) << (dpc_pkg::DIV_BITS - 1 - (g - 3 - dpc_pkg::SQRT_STEPS));
          if (62'(w.rc) >= tq) begin
            w.rc = 61'(62'(w.rc) - tq);
            w.qc = w.qc | (61'd1 << (dpc_pkg::DIV_BITS - 1 - (g - 3 - dpc_pkg::SQRT_STEPS)));
          end
          if (62'(w.rs) >= tq) begin
            w.rs = 61'(62'(w.rs) - tq);
            w.qs = w.qs | (61'd1 << (dpc_pkg::DIV_BITS - 1 - (g - 3 - dpc_pkg::SQRT_STEPS)));
          end
        end else if (g == D - 6) begin
          w.c = w.dxn ? -32'(w.qc) : 32'(w.qc);
          w.s = w.dyn ? -32'(w.qs) : 32'(w.qs);
          w.t0 = 68'(w.pair.first_vx) - 68'(w.pair.second_vx);
          w.t1 = 68'(w.pair.first_vy) - 68'(w.pair.second_vy);
        end else if (g == D - 5) begin
          p0 = smul(35'(w.t0), w.s);
          p1 = smul(35'(w.t1), w.c);
          w.t2 = rshr(p0 - p1);
          p0 = smul(35'(w.t0), w.c);
          p1 = smul(35'(w.t1), w.s);
          w.t3 = rshr(p0 + p1);
        end else if (g == D - 4) begin
          w.t0 = 68'(w.pair.second_vx) + rshr(smul(35'(w.t2), w.s));
          w.t1 = 68'(w.pair.second_vy) - rshr(smul(35'(w.t2), w.c));
          w.t2 = 68'(w.pair.second_vx) + rshr(smul(35'(w.t3), w.c));
          w.t3 = 68'(w.pair.second_vy) + rshr(smul(35'(w.t3), w.s));
        end else if (g == D - 3) begin
          w.t0 = (smul(35'(w.t0), 32'($signed({1'b0, velocity_scale}))) + 68'sd32768) >>> 16;
          w.t1 = (smul(35'(w.t1), 32'($signed({1'b0, velocity_scale}))) + 68'sd32768) >>> 16;
          w.t2 = (smul(35'(w.t2), 32'($signed({1'b0, velocity_scale}))) + 68'sd32768) >>> 16;
          w.t3 = (smul(35'(w.t3), 32'($signed({1'b0, velocity_scale}))) + 68'sd32768) >>> 16;
        end else if (g == D - 2) begin
          if (w.act) begin
            w.pair.first_vx = dpc_pkg::sat32(w.t0);
            w.pair.first_vy = dpc_pkg::sat32(w.t1);
            w.pair.second_vx = dpc_pkg::sat32(w.t2);
            w.pair.second_vy = dpc_pkg::sat32(w.t3);
          end
          push = 33'(twor) - 33'(w.root2);
          w.t0 = rshr(smul(35'(push), w.c));
          w.t1 = rshr(smul(35'(push), w.s));
        end else begin
          if (w.act && w.ov) begin
            if (w.dyp) begin
              w.pair.first_x = dpc_pkg::sat32(68'(w.pair.first_x) + w.t0);
              w.pair.first_y = dpc_pkg::sat32(68'(w.pair.first_y) + w.t1);
            end else begin
              w.pair.second_x = dpc_pkg::sat32(68'(w.pair.second_x) - w.t0);
              w.pair.second_y = dpc_pkg::sat32(68'(w.pair.second_y) - w.t1);
            end
          end
        end
        nx = w;
      end

      dpc_stage u_stage (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(vld[g]), .in_data(nx),
        .out_valid(vld[g+1]), .out_data(st[g+1])
      );
    end
  endgenerate

  assign m_axis_tvalid = vld[D];
  assign m_axis_tdata = {6'd0, st[D].coin, st[D].act, st[D].pair};

  `DPC_ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output item dropped during stall")
  `DPC_ASSERT_IMPL(a_flags, clk, rst, m_axis_tvalid, !(m_axis_tdata[256] && m_axis_tdata[257]), "collided and coincident both set")
  `DPC_ASSERT_IMPL(a_ready, clk, rst, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
endmodule

### test/disk_pair_collision_response_core_tb.sv
// Testbench for the disk pair collision response core: directed and random disk pairs,
// with a behavioral predictor of the collision response and field-by-field result checks.
// Depends on dpc_pkg and the disk_pair_collision_response_core RTL.
`timescale 1ns / 100ps
module disk_pair_collision_response_core_tb;

  typedef struct {
    logic [31:0] f[8];
    logic collided;
    logic coincident;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [263:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = dpc_pkg::CFG_VELOCITY_SCALE;
  logic [31:0] cfg_data = '0;

  logic [255:0] pending_pairs[$];
  response_t expected_responses[$];
  logic [16:0] scale_reg;
  logic [24:0] radius_reg;
  int errors = 0;
  int accepted = 0;
  int collided_count = 0;
  int overlap_seen = 0;
  int cycles = 0;
  int hold_off = 0;
  int calm = 0;
  bit input_idle = 1'b0;
  bit output_idle = 1'b0;
  bit in_taken = 1'b0;

  disk_pair_collision_response_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint round_shift(longint x, int k);
    return (x + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit approaching(longint x1, longint y1, longint vx1, longint vy1,
                                     longint x2, longint y2, longint vx2, longint vy2);
    longint rx = (x1 < x2) ? vx1 - vx2 : vx2 - vx1;
    longint ry = (y1 < y2) ? vy1 - vy2 : vy2 - vy1;
    if (rx > 0 && ry > 0) return 1'b1;
    if (rx < 0 && ry < 0) return 1'b0;
    if (rx > 0 && ry < 0) return rx > ry;
    return ry > rx;
  endfunction

  function automatic longint restitute(longint v);
    return clamp32(round_shift(v * longint'(scale_reg), dpc_pkg::SCALE_BITS));
  endfunction

  function automatic response_t collide_pair(logic [255:0] pair);
    response_t r;
    longint v[8];
    longint dx, dy, c, s, dux, duy, perp, along, push, mx, my;
    longint unsigned ma, mb, m, a, b, d, twor, d2;
    for (int i = 0; i < 8; i++) v[i] = longint'($signed(pair[32*i +: 32]));
    dx = v[0] - v[4];
    dy = v[1] - v[5];
    r.coincident = (dx == 0 && dy == 0);
    r.collided = 1'b0;
    if (!r.coincident && approaching(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7])) begin
      r.collided = 1'b1;
      ma = (dx < 0) ? -dx : dx;
      mb = (dy < 0) ? -dy : dy;
      m = (ma > mb) ? ma : mb;
      a = ma;
      b = mb;
      while (m >= (64'd1 << 29)) begin
        m = m >> 1; a = a >> 1; b = b >> 1;
      end
      while (m < (64'd1 << 28)) begin
        m = m << 1; a = a << 1; b = b << 1;
      end
      d = floor_root(a * a + b * b);
      c = longint'((a << dpc_pkg::UNIT_BITS) / d);
      s = longint'((b << dpc_pkg::UNIT_BITS) / d);
      if (dx < 0) c = -c;
      if (dy < 0) s = -s;
      dux = v[2] - v[6];
      duy = v[3] - v[7];
      perp = round_shift(dux * s - duy * c, dpc_pkg::UNIT_BITS);
      along = round_shift(dux * c + duy * s, dpc_pkg::UNIT_BITS);
      v[2] = restitute(v[6] + round_shift(perp * s, dpc_pkg::UNIT_BITS));
      v[3] = restitute(v[7] - round_shift(perp * c, dpc_pkg::UNIT_BITS));
      v[6] = restitute(longint'($signed(pair[32*6 +: 32]))
                       + round_shift(along * c, dpc_pkg::UNIT_BITS));
      v[7] = restitute(longint'($signed(pair[32*7 +: 32]))
                       + round_shift(along * s, dpc_pkg::UNIT_BITS));
      twor = 2 * longint'(radius_reg);
      if (ma < twor && mb < twor) begin
        d2 = ma * ma + mb * mb;
        if (d2 < twor * twor) begin
          overlap_seen++;
          push = longint'(twor - floor_root(d2));
          mx = round_shift(push * c, dpc_pkg::UNIT_BITS);
          my = round_shift(push * s, dpc_pkg::UNIT_BITS);
          if (dy > 0) begin
            v[0] = clamp32(v[0] + mx);
            v[1] = clamp32(v[1] + my);
          end else begin
            v[4] = clamp32(v[4] - mx);
            v[5] = clamp32(v[5] - my);
          end
        end
      end
    end
    for (int i = 0; i < 8; i++) r.f[i] = v[i][31:0];
    return r;
  endfunction

  function automatic void add_pair(logic [255:0] p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  // Driver: an offered item is held until it is accepted.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_taken) begin
        input_idle = (calm == 0) && ($urandom_range(99) < 35);
        if (pending_pairs.size() > 0 && !input_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_pairs[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        output_idle = (calm == 0) && ($urandom_range(99) < 35);
        m_axis_tready <= !output_idle;
      end
      if (calm > 0) calm--;
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // Monitor: a pair is predicted when it is accepted, so register changes apply in order.
  always @(posedge clk) begin
    response_t e;
    cycles++;
    in_taken = 1'b0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_responses.insert(expected_responses.size(), collide_pair(s_axis_tdata));
      accepted++;
      void'(pending_pairs.pop_front());
      in_taken = 1'b1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = expected_responses.pop_front();
        if (e.collided) collided_count++;
        for (int i = 0; i < 8; i++)
          if (m_axis_tdata[32*i +: 32] !== e.f[i]) begin
            $display("%0t: field %0d expected %h actual %h", $time, i, e.f[i],
                     m_axis_tdata[32*i +: 32]);
            errors++;
          end
        if (m_axis_tdata[256] !== e.collided || m_axis_tdata[257] !== e.coincident) begin
          $display("%0t: flags expected %b%b actual %b%b", $time, e.coincident, e.collided,
                   m_axis_tdata[257], m_axis_tdata[256]);
          errors++;
        end
      end
    end
    if (cycles > 400000) begin
      $display("%0t: timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [255:0] make_pair(logic [31:0] x1, logic [31:0] y1, logic [31:0] vx1,
                                            logic [31:0] vy1, logic [31:0] x2, logic [31:0] y2,
                                            logic [31:0] vx2, logic [31:0] vy2);
    return {vy2, vx2, y2, x2, vy1, vx1, y1, x1};
  endfunction

  function automatic logic [31:0] near_val(logic [31:0] base, int spread);
    return base + $urandom_range(2 * spread) - spread;
  endfunction

  function automatic logic [255:0] random_pair();
    logic [31:0] f[8];
    int spread;
    case ($urandom_range(9))
      0: for (int i = 0; i < 8; i++) f[i] = $urandom();
      1: for (int i = 0; i < 8; i++)
           f[i] = $urandom_range(1) ? ($urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000)
                                    : $urandom();
      default: begin
        spread = 1 << $urandom_range(20, 14);
        f[0] = $urandom();
        f[1] = $urandom();
        f[4] = near_val(f[0], spread);
        f[5] = $urandom_range(7) == 0 ? f[1] : near_val(f[1], spread);
        if ($urandom_range(15) == 0) f[4] = f[0];
        for (int i = 2; i < 4; i++) begin
          f[i] = $signed(near_val(0, 1 << $urandom_range(22, 10)));
          f[i + 4] = $signed(near_val(0, 1 << $urandom_range(22, 10)));
        end
      end
    endcase
    return make_pair(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]);
  endfunction

  task automatic write_register(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == dpc_pkg::CFG_VELOCITY_SCALE) scale_reg = value[16:0];
    else radius_reg = value[24:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || expected_responses.size() > 0) @(posedge clk);
    repeat (dpc_pkg::PIPE_DEPTH + 20) @(posedge clk);
  endtask

  initial begin
    scale_reg = 17'd65536;
    radius_reg = 25'd65536;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: coincident centers, head-on, overlap above and below, extremes.
    add_pair(make_pair(32'h10000, 32'h20000, 32'h10000, 0, 32'h10000, 32'h20000,
                       32'hFFFF0000, 0));
    add_pair(make_pair(0, 0, 32'h10000, 0, 32'h18000, 0, 32'hFFFF0000, 0));
    add_pair(make_pair(0, 32'h8000, 0, 32'hFFFF0000, 32'h4000, 0, 0, 32'h10000));
    add_pair(make_pair(0, 0, 0, 32'h10000, 32'h4000, 32'h8000, 0, 32'hFFFF0000));
    add_pair(make_pair(0, 0, 32'hFFFF0000, 0, 32'h18000, 0, 32'h10000, 0));
    add_pair(make_pair(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000));
    add_pair(make_pair(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                       32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));
    add_pair(make_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                       0, 0, 0, 0));
    add_pair(make_pair(0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 1,
                       32'h80000000, 32'h80000000));
    add_pair(make_pair(32'h7FFFFFF0, 0, 32'h100000, 0, 32'h7FFFFFFF, 0, 0, 0));
    for (int i = 0; i < 6; i++) add_pair(random_pair());
    drain();

    // Random phases over several register settings.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_register(dpc_pkg::CFG_VELOCITY_SCALE, 0);
          write_register(dpc_pkg::CFG_PARTICLE_RADIUS, 0);
        end
        1: begin
          write_register(dpc_pkg::CFG_VELOCITY_SCALE, 17'h1FFFF);
          write_register(dpc_pkg::CFG_PARTICLE_RADIUS, 25'h1FFFFFF);
        end
        2: begin
          write_register(dpc_pkg::CFG_VELOCITY_SCALE, 65536);
          write_register(dpc_pkg::CFG_PARTICLE_RADIUS, 25'h1000000);
        end
        default: begin
          write_register(dpc_pkg::CFG_VELOCITY_SCALE, $urandom_range(65536));
          write_register(dpc_pkg::CFG_PARTICLE_RADIUS, $urandom_range(25'h1FFFFFF));
        end
      endcase
      if (phase == 2) calm = 600;
      if (phase == 3) hold_off = 300;
      for (int i = 0; i < 250; i++) add_pair(random_pair());
      drain();
    end

    $display("Covered %0d pairs, %0d collided, %0d overlap pushes, under the reset", accepted,
             collided_count, overlap_seen);
    $display("register values and five further settings, with random stalls on both sides.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
